// File: src/linear_blend_vertex_skinning_assert.svh
// Assertion macros for the skinning block.
// Each module that asserts needs clk_i and rst_ni in scope.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication in the same cycle.
`define LBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lbs_pkg.sv
// Shared constants, types and saturation helper for the skinning block.
// No dependencies.
package lbs_pkg;

  localparam int BONE_COUNT     = 64;
  localparam int MAX_INFLUENCES = 4;
  localparam int BONE_AW        = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
  localparam int MAT_ROWS       = 4;
  localparam int ROW_W          = 96;

  localparam logic [2:0]  REQ_ROW_WRITE = 3'd0;
  localparam logic [17:0] ONE_Q16       = 18'd65536;

  typedef logic [BONE_AW-1:0] bone_addr_t;

  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic                oor;
    logic [16:0]         weight;
    logic signed [31:0]  px;
    logic signed [31:0]  py;
    logic signed [31:0]  pz;
    bone_addr_t          addr;
  } step_t;

  typedef struct packed {
    logic             we;
    logic [1:0]       row;
    bone_addr_t       addr;
    logic [ROW_W-1:0] data;
  } wr_t;

  function automatic logic signed [31:0] sat32(logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) r = 32'sh7fffffff;
    else if (v < -52'sd2147483648) r = 32'sh80000000;
    else r = $signed(v[31:0]);
    return r;
  endfunction

endpackage

// File: src/linear_blend_vertex_skinning.sv
// Top level of the four-bone linear blend skinning block.
// Depends on lbs_pkg, lbs_ram, lbs_issue, lbs_dp.
//
//  channel   dir  tdata                         tuser
//  s_axis    in   bones, weights, vec, row      req_type
//  m_axis    out  out_x, out_y, out_z           -
//
// A row write is one accepted word; a vertex with N bones issues N bone steps (one
// matrix read per bone from the four row memories, all read in parallel).
// The next word can be taken during a vertex's last bone step, unless m_axis stalls.
// Reset clears pipeline control only; matrix memory is undefined until written.
// A stall on m_axis freezes the whole pipeline; the matrix read data is held.

module linear_blend_vertex_skinning (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bone_a[5:0] bone_b[11:6] bone_c[17:12] bone_d[23:18] weight_a[39:24]
  // weight_b[55:40] weight_c[71:56] vec_x[103:72] vec_y[135:104]
  // vec_z[167:136] row_index[169:168], zero pad
  input  logic [175:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[31:0] out_y[63:32] out_z[95:64]
  output logic [95:0]  m_axis_tdata
);

  logic                adv;
  lbs_pkg::step_t      step;
  lbs_pkg::wr_t        wr;
  lbs_pkg::bone_addr_t raddr;
  logic [lbs_pkg::ROW_W-1:0] rdata [lbs_pkg::MAT_ROWS];

  assign adv   = !m_axis_tvalid || m_axis_tready;
  assign raddr = step.addr;

  lbs_issue u_issue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_axis_tvalid),
    .in_user_i (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .adv_i     (adv),
    .in_rdy_o  (s_axis_tready),
    .step_o    (step),
    .wr_o      (wr)
  );

  for (genvar r = 0; r < lbs_pkg::MAT_ROWS; r++) begin : g_row
    lbs_ram #(
      .W (lbs_pkg::ROW_W),
      .D (lbs_pkg::BONE_COUNT)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr.we && (wr.row == 2'(r))),
      .waddr_i (wr.addr),
      .wdata_i (wr.data),
      .re_i    (adv),
      .raddr_i (raddr),
      .rdata_o (rdata[r])
    );
  end

  lbs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .step_i     (step),
    .rdata_i    (rdata),
    .out_vld_o  (m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule

// File: src/lbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbs_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]   waddr_i,
  input  logic [W-1:0]                           wdata_i,
  input  logic                                   re_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]   raddr_i,
  output logic [W-1:0]                           rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lbs_issue.sv
// Input stage: takes words, issues row writes, steps through a vertex's bones.
// Depends on lbs_pkg and the assertion header.
`include "linear_blend_vertex_skinning_assert.svh"

module lbs_issue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_vld_i,
  input  logic [2:0]     in_user_i,
  input  logic [175:0]   in_data_i,
  input  logic           adv_i,
  output logic           in_rdy_o,
  output lbs_pkg::step_t step_o,
  output lbs_pkg::wr_t   wr_o
);

  logic               busy_q;
  logic [1:0]         cnt_q;
  logic [2:0]         n_q;
  logic [5:0]         bones_q [4];
  logic [16:0]        wts_q   [4];
  logic signed [31:0] px_q, py_q, pz_q;

  logic [5:0]   bone_in [4];
  logic [15:0]  w_in    [4];
  logic [16:0]  wts_d   [4];
  logic [17:0]  given;
  logic [16:0]  last_w;
  logic         at_last;
  logic         acc;
  logic         take_vtx;
  logic [5:0]   cur_bone;

  assign bone_in[0] = in_data_i[5:0];
  assign bone_in[1] = in_data_i[11:6];
  assign bone_in[2] = in_data_i[17:12];
  assign bone_in[3] = in_data_i[23:18];
  assign w_in[0]    = in_data_i[39:24];
  assign w_in[1]    = in_data_i[55:40];
  assign w_in[2]    = in_data_i[71:56];
  assign w_in[3]    = '0;

  assign at_last  = ({1'b0, cnt_q} == (n_q - 3'd1));
  assign in_rdy_o = adv_i && (!busy_q || at_last);
  assign acc      = in_vld_i && in_rdy_o;
  assign take_vtx = acc && (in_user_i != lbs_pkg::REQ_ROW_WRITE)
                    && (32'(in_user_i) <= 32'(lbs_pkg::MAX_INFLUENCES));

  always_comb begin
    given = '0;
    for (int i = 0; i < 3; i++) begin
      if (3'(i + 1) < in_user_i) given = given + 18'(w_in[i]);
    end
    last_w = (given >= lbs_pkg::ONE_Q16) ? 17'd0 : 17'(lbs_pkg::ONE_Q16 - given);
    for (int i = 0; i < 4; i++) begin
      wts_d[i] = (3'(i + 1) == in_user_i) ? last_w : {1'b0, w_in[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
    end else if (take_vtx) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      n_q    <= in_user_i;
    end else if (adv_i && busy_q) begin
      if (at_last) busy_q <= 1'b0;
      else cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_vtx) begin
      bones_q <= bone_in;
      wts_q   <= wts_d;
      px_q    <= $signed(in_data_i[103:72]);
      py_q    <= $signed(in_data_i[135:104]);
      pz_q    <= $signed(in_data_i[167:136]);
    end
  end

  assign cur_bone = bones_q[cnt_q];

  always_comb begin
    step_o.vld    = busy_q;
    step_o.first  = (cnt_q == 2'd0);
    step_o.last   = at_last;
    step_o.oor    = 32'(cur_bone) >= 32'(lbs_pkg::BONE_COUNT);
    step_o.weight = wts_q[cnt_q];
    step_o.px     = px_q;
    step_o.py     = py_q;
    step_o.pz     = pz_q;
    step_o.addr   = lbs_pkg::BONE_AW'(cur_bone);
  end

  always_comb begin
    wr_o.we   = acc && (in_user_i == lbs_pkg::REQ_ROW_WRITE)
                && (32'(bone_in[0]) < 32'(lbs_pkg::BONE_COUNT));
    wr_o.row  = in_data_i[169:168];
    wr_o.addr = lbs_pkg::BONE_AW'(bone_in[0]);
    wr_o.data = in_data_i[167:72];
  end

  `LBS_ASSERT_IMPL(a_cnt_range, busy_q, ({1'b0, cnt_q} < n_q), "bone step past count")
  `LBS_ASSERT_IMPL(a_n_range, busy_q,
    (n_q != 3'd0) && (32'(n_q) <= 32'(lbs_pkg::MAX_INFLUENCES)), "bad bone count")
  `LBS_ASSERT_NEXT(a_hold, busy_q && !adv_i, busy_q && $stable(cnt_q), "step moved in stall")

endmodule

// File: src/lbs_dp.sv
// Arithmetic pipeline: matrix transform, weighting, blend accumulation, output.
// Depends on lbs_pkg and the assertion header.
`include "linear_blend_vertex_skinning_assert.svh"

module lbs_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  lbs_pkg::step_t           step_i,
  input  logic [lbs_pkg::ROW_W-1:0] rdata_i [lbs_pkg::MAT_ROWS],
  output logic                     out_vld_o,
  output logic [95:0]              out_data_o
);

  // stage 1: matrix data arrives
  logic               s1_vld_q;
  lbs_pkg::step_t     s1_q;
  logic signed [31:0] mat  [4][3];
  logic signed [31:0] pos  [3];
  logic signed [63:0] prod [3][3];

  // stage 2: products
  logic               s2_vld_q, s2_first_q, s2_last_q;
  logic [16:0]        s2_w_q;
  logic signed [63:0] prod_q  [3][3];
  logic signed [31:0] trans_q [3];
  logic signed [49:0] tsum    [3];

  // stage 3: transformed point
  logic               s3_vld_q, s3_first_q, s3_last_q;
  logic [16:0]        s3_w_q;
  logic signed [31:0] pt_q [3];
  logic signed [49:0] wp   [3];

  // stage 4: weighted point, accumulate
  logic               s4_vld_q, s4_first_q, s4_last_q;
  logic signed [49:0] wp_q   [3];
  logic signed [51:0] acc_q  [3];
  logic signed [51:0] acc_n  [3];
  logic signed [51:0] rnd    [3];

  logic               out_vld_q;
  logic signed [31:0] out_q [3];

  assign pos[0] = s1_q.px;
  assign pos[1] = s1_q.py;
  assign pos[2] = s1_q.pz;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        mat[r][c] = s1_q.oor ? 32'sd0 : $signed(rdata_i[r][c*32 +: 32]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = pos[r] * mat[r][c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tsum[c] = 50'(trans_q[c]) + 50'($signed(prod_q[0][c][63:16]))
              + 50'($signed(prod_q[1][c][63:16])) + 50'($signed(prod_q[2][c][63:16]));
      wp[c]   = pt_q[c] * $signed({1'b0, s3_w_q});
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_n[c] = (s4_first_q ? 52'sd0 : acc_q[c]) + 52'(wp_q[c]);
      rnd[c]   = acc_n[c] + 52'sd32768;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q  <= step_i.vld;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q && s4_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q        <= step_i;
      s2_first_q  <= s1_q.first;
      s2_last_q   <= s1_q.last;
      s2_w_q      <= s1_q.weight;
      prod_q      <= prod;
      trans_q     <= mat[3];
      s3_first_q  <= s2_first_q;
      s3_last_q   <= s2_last_q;
      s3_w_q      <= s2_w_q;
      s4_first_q  <= s3_first_q;
      s4_last_q   <= s3_last_q;
      wp_q        <= wp;
      for (int c = 0; c < 3; c++) begin
        pt_q[c] <= lbs_pkg::sat32(52'(tsum[c]));
      end
      if (s4_vld_q) acc_q <= acc_n;
      if (s4_vld_q && s4_last_q) begin
        for (int c = 0; c < 3; c++) begin
          out_q[c] <= lbs_pkg::sat32(rnd[c] >>> 16);
        end
      end
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = {out_q[2], out_q[1], out_q[0]};

  `LBS_ASSERT_NEXT(a_acc_hold, !adv_i, $stable(acc_q[0]) && $stable(s4_vld_q),
    "accumulator moved in stall")
  `LBS_ASSERT_IMPL(a_adv, !out_vld_q, adv_i, "pipeline stalled with empty output")
  `LBS_ASSERT_NEXT(a_out_src, adv_i && !(s4_vld_q && s4_last_q), !out_vld_q,
    "result without last bone")

endmodule
